FILE: rtl/pa_pkg.sv
package pa_pkg;

	// pipeline depths of the cell rows
	localparam int unsigned SqrtSteps = 32;
	localparam int unsigned Div1Steps = 17;
	localparam int unsigned Div2Steps = 18;

	localparam logic [31:0] OneQ16   = 32'h0001_0000;
	localparam logic [31:0] HalfQ16  = 32'h0000_8000;
	localparam logic [16:0] DampQ16  = 17'd64881;
	localparam logic [6:0]  StepScale = 7'd100;

	localparam logic [12:0] WidthReset  = 13'd800;
	localparam logic [12:0] HeightReset = 13'd450;

	typedef enum logic [0:0] {
		RegWidth  = 1'b0,
		RegHeight = 1'b1
	} reg_idx_t;

	// one particle in flight through the cell rows
	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [22:0] kdt;
		logic        sx;
		logic        sy;
		logic [31:0] mag_x;
		logic [31:0] mag_y;
		logic [62:0] sqa;
		logic [62:0] sqb;
		logic [63:0] rad;
		logic [32:0] srem;
		logic [31:0] root;
		logic [31:0] dv;
		logic [31:0] rx;
		logic [31:0] ry;
		logic [17:0] qx;
		logic [17:0] qy;
	} tok_t;

endpackage

FILE: rtl/pa_sqrt_cell.sv
module pa_sqrt_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         vld_in,
	input  pa_pkg::tok_t tok_in,
	output logic         vld_out,
	output pa_pkg::tok_t tok_out
);
	import pa_pkg::*;

	tok_t        nxt;
	tok_t        tok_q;
	logic        vld_q;
	logic [34:0] rem_t;
	logic [34:0] trial;
	logic [34:0] diff;

	// bring down two radicand bits, try the next root bit
	always_comb begin
		nxt   = tok_in;
		rem_t = {tok_in.srem, tok_in.rad[63:62]};
		trial = {1'b0, tok_in.root, 2'b01};
		diff  = rem_t - trial;
		nxt.rad = {tok_in.rad[61:0], 2'b00};
		if (rem_t >= trial) begin
			nxt.srem = diff[32:0];
			nxt.root = {tok_in.root[30:0], 1'b1};
		end else begin
			nxt.srem = rem_t[32:0];
			nxt.root = {tok_in.root[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign tok_out = tok_q;

endmodule

FILE: rtl/pa_div_cell.sv
module pa_div_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         vld_in,
	input  pa_pkg::tok_t tok_in,
	output logic         vld_out,
	output pa_pkg::tok_t tok_out
);
	import pa_pkg::*;

	tok_t nxt;
	tok_t tok_q;
	logic vld_q;

	// one restoring step: remainder in upper bits, dividend feed and quotient in q
	function automatic logic [49:0] div_step(input logic [31:0] r, input logic [17:0] q,
			input logic [31:0] dv);
		logic [32:0] rem_t;
		logic [32:0] diff;
		rem_t = {r, q[17]};
		diff  = rem_t - {1'b0, dv};
		if (rem_t >= {1'b0, dv}) begin
			div_step = {diff[31:0], q[16:0], 1'b1};
		end else begin
			div_step = {rem_t[31:0], q[16:0], 1'b0};
		end
	endfunction

	always_comb begin
		nxt = tok_in;
		{nxt.rx, nxt.qx} = div_step(tok_in.rx, tok_in.qx, tok_in.dv);
		{nxt.ry, nxt.qy} = div_step(tok_in.ry, tok_in.qy, tok_in.dv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign tok_out = tok_q;

endmodule

FILE: rtl/particle_attract_step.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | pos_x pos_y vel_x vel_y attract_x attract_y frame_delta
// out     | output    | out_valid/out_ready | new_pos_x new_pos_y new_vel_x new_vel_y
// cfg     | input     | APB psel/penable    | screen_width (0x0), screen_height (0x4)
// One item per cycle while the output register is empty or taken.
// The pipeline is a row of 32 square-root cells and two rows of divider cells
// (17 and 18), plus front and back arithmetic stages.
// All stages advance together whenever the output register is empty or taken.
// Reset clears stage valid bits and loads the screen size registers.
module particle_attract_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] attract_x,
	input  logic [31:0] attract_y,
	input  logic [15:0] frame_delta,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] new_pos_x,
	output logic [31:0] new_pos_y,
	output logic [31:0] new_vel_x,
	output logic [31:0] new_vel_y,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pa_pkg::*;

	function automatic logic [31:0] sat32(input logic signed [41:0] v);
		if (v > 42'sh0_7FFF_FFFF) begin
			sat32 = 32'h7FFF_FFFF;
		end else if (v < -42'sh0_8000_0000) begin
			sat32 = 32'h8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	logic        adv;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic        wr_en;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[2]))
				RegWidth:  width_q  <= pwdata[12:0];
				RegHeight: height_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			RegWidth:  prdata = {19'd0, width_q};
			RegHeight: prdata = {19'd0, height_q};
			default:   prdata = 32'd0;
		endcase
	end

	// whole pipeline moves as one
	logic out_vld_q;
	assign adv      = !out_vld_q || out_ready;
	assign in_ready = adv;

	tok_t tok_s1, tok_s2, tok_s3, tok_s4, tok_s5, tok_s6;
	tok_t tok_n1, tok_n2, tok_n3, tok_n4, tok_n5, tok_n6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [32:0] dx_w, dy_w;

	tok_t sq_tok [0:SqrtSteps];
	logic sq_vld [0:SqrtSteps];
	tok_t d1_tok [0:Div1Steps];
	logic d1_vld [0:Div1Steps];
	tok_t d2_tok [0:Div2Steps];
	logic d2_vld [0:Div2Steps];

	assign dx_w = {pos_x[31], pos_x} - {attract_x[31], attract_x};
	assign dy_w = {pos_y[31], pos_y} - {attract_y[31], attract_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= sq_vld[SqrtSteps];
			vld_s6 <= d1_vld[Div1Steps];
		end
	end

	// front stages: offset, magnitude, squares, radicand
	always_comb begin
		tok_n1       = '0;
		tok_n1.pos_x = pos_x;
		tok_n1.pos_y = pos_y;
		tok_n1.vel_x = vel_x;
		tok_n1.vel_y = vel_y;
		tok_n1.kdt   = 23'(frame_delta) * 23'(StepScale);
		tok_n1.mag_x = sat32(42'($signed(dx_w)));
		tok_n1.mag_y = sat32(42'($signed(dy_w)));
	end

	always_comb begin
		tok_n2       = tok_s1;
		tok_n2.sx    = tok_s1.mag_x[31];
		tok_n2.sy    = tok_s1.mag_y[31];
		tok_n2.mag_x = tok_s1.mag_x[31] ? (32'd0 - tok_s1.mag_x) : tok_s1.mag_x;
		tok_n2.mag_y = tok_s1.mag_y[31] ? (32'd0 - tok_s1.mag_y) : tok_s1.mag_y;
	end

	always_comb begin
		tok_n3     = tok_s2;
		tok_n3.sqa = {31'd0, tok_s2.mag_x} * {31'd0, tok_s2.mag_x};
		tok_n3.sqb = {31'd0, tok_s2.mag_y} * {31'd0, tok_s2.mag_y};
	end

	always_comb begin
		tok_n4      = tok_s3;
		tok_n4.rad  = {1'b0, tok_s3.sqa} + {1'b0, tok_s3.sqb};
		tok_n4.srem = '0;
		tok_n4.root = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1 <= tok_n1;
			tok_s2 <= tok_n2;
			tok_s3 <= tok_n3;
			tok_s4 <= tok_n4;
		end
	end

	assign sq_tok[0] = tok_s4;
	assign sq_vld[0] = vld_s4;

	for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
		pa_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (sq_vld[i]),
			.tok_in  (sq_tok[i]),
			.vld_out (sq_vld[i+1]),
			.tok_out (sq_tok[i+1])
		);
	end

	// set up offset / length: zero length counts as one
	always_comb begin
		tok_n5    = sq_tok[SqrtSteps];
		tok_n5.dv = (sq_tok[SqrtSteps].root == 32'd0) ? OneQ16 : sq_tok[SqrtSteps].root;
		tok_n5.rx = {1'b0, sq_tok[SqrtSteps].mag_x[31:1]};
		tok_n5.ry = {1'b0, sq_tok[SqrtSteps].mag_y[31:1]};
		tok_n5.qx = {sq_tok[SqrtSteps].mag_x[0], 17'd0};
		tok_n5.qy = {sq_tok[SqrtSteps].mag_y[0], 17'd0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s5 <= tok_n5;
		end
	end

	assign d1_tok[0] = tok_s5;
	assign d1_vld[0] = vld_s5;

	for (genvar i = 0; i < Div1Steps; i++) begin : g_div1
		pa_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (d1_vld[i]),
			.tok_in  (d1_tok[i]),
			.vld_out (d1_vld[i+1]),
			.tok_out (d1_tok[i+1])
		);
	end

	// set up normal / clamped length
	always_comb begin
		tok_n6    = d1_tok[Div1Steps];
		tok_n6.dv = (d1_tok[Div1Steps].dv < HalfQ16) ? HalfQ16 : d1_tok[Div1Steps].dv;
		tok_n6.rx = {17'd0, d1_tok[Div1Steps].qx[16:2]};
		tok_n6.ry = {17'd0, d1_tok[Div1Steps].qy[16:2]};
		tok_n6.qx = {d1_tok[Div1Steps].qx[1:0], 16'd0};
		tok_n6.qy = {d1_tok[Div1Steps].qy[1:0], 16'd0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s6 <= tok_n6;
		end
	end

	assign d2_tok[0] = tok_s6;
	assign d2_vld[0] = vld_s6;

	for (genvar i = 0; i < Div2Steps; i++) begin : g_div2
		pa_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (d2_vld[i]),
			.tok_in  (d2_tok[i]),
			.vld_out (d2_vld[i+1]),
			.tok_out (d2_tok[i+1])
		);
	end

	// back stages: pull, damping, step, wrap
	tok_t                d2o;
	logic signed [33:0]  gx, gy;
	logic [31:0]         pos_x_s7, pos_y_s7, pos_x_s8, pos_y_s8, pos_x_s9, pos_y_s9;
	logic [31:0]         pos_x_s10, pos_y_s10, pos_x_s11, pos_y_s11;
	logic [22:0]         kdt_s7, kdt_s8, kdt_s9;
	logic [31:0]         v1x_s7, v1y_s7;
	logic signed [49:0]  mx_s8, my_s8;
	logic [31:0]         v2x_s9, v2y_s9, v2x_s10, v2y_s10, v2x_s11, v2y_s11;
	logic [31:0]         v2x_s12, v2y_s12, v2x_s13, v2y_s13;
	logic signed [55:0]  stx_s10, sty_s10;
	logic signed [39:0]  sx_s11, sy_s11;
	logic [31:0]         px_s12, py_s12, px_s13, py_s13;
	logic signed [49:0]  mx_r, my_r;
	logic signed [55:0]  stx_r, sty_r;
	logic signed [40:0]  psx, psy;
	logic signed [32:0]  wx, wy;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;

	// pull takes the sign of the offset
	assign d2o = d2_tok[Div2Steps];
	assign gx  = d2o.sx ? -$signed({16'd0, d2o.qx}) : $signed({16'd0, d2o.qx});
	assign gy  = d2o.sy ? -$signed({16'd0, d2o.qy}) : $signed({16'd0, d2o.qy});

	assign mx_r  = mx_s8 + 50'sd32768;
	assign my_r  = my_s8 + 50'sd32768;
	assign stx_r = stx_s10 + 56'sd32768;
	assign sty_r = sty_s10 + 56'sd32768;
	assign psx   = 41'($signed(pos_x_s11)) + 41'(sx_s11);
	assign psy   = 41'($signed(pos_y_s11)) + 41'(sy_s11);
	assign wx    = {1'b0, 3'd0, width_q, 16'd0};
	assign wy    = {1'b0, 3'd0, height_q, 16'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			vld_s10   <= 1'b0;
			vld_s11   <= 1'b0;
			vld_s12   <= 1'b0;
			vld_s13   <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s7    <= d2_vld[Div2Steps];
			vld_s8    <= vld_s7;
			vld_s9    <= vld_s8;
			vld_s10   <= vld_s9;
			vld_s11   <= vld_s10;
			vld_s12   <= vld_s11;
			vld_s13   <= vld_s12;
			out_vld_q <= vld_s13;
		end
	end

	logic [31:0] npx_q, npy_q, nvx_q, nvy_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			// subtract pull from velocity
			v1x_s7   <= sat32(42'($signed(d2o.vel_x)) - 42'(gx));
			v1y_s7   <= sat32(42'($signed(d2o.vel_y)) - 42'(gy));
			pos_x_s7 <= d2o.pos_x;
			pos_y_s7 <= d2o.pos_y;
			kdt_s7   <= d2o.kdt;

			// damp
			mx_s8    <= 50'($signed(v1x_s7) * $signed({1'b0, DampQ16}));
			my_s8    <= 50'($signed(v1y_s7) * $signed({1'b0, DampQ16}));
			pos_x_s8 <= pos_x_s7;
			pos_y_s8 <= pos_y_s7;
			kdt_s8   <= kdt_s7;

			v2x_s9   <= sat32(42'(mx_r >>> 16));
			v2y_s9   <= sat32(42'(my_r >>> 16));
			pos_x_s9 <= pos_x_s8;
			pos_y_s9 <= pos_y_s8;
			kdt_s9   <= kdt_s8;

			// position step
			stx_s10   <= 56'($signed(v2x_s9) * $signed({1'b0, kdt_s9}));
			sty_s10   <= 56'($signed(v2y_s9) * $signed({1'b0, kdt_s9}));
			v2x_s10   <= v2x_s9;
			v2y_s10   <= v2y_s9;
			pos_x_s10 <= pos_x_s9;
			pos_y_s10 <= pos_y_s9;

			sx_s11    <= 40'(stx_r >>> 16);
			sy_s11    <= 40'(sty_r >>> 16);
			v2x_s11   <= v2x_s10;
			v2y_s11   <= v2y_s10;
			pos_x_s11 <= pos_x_s10;
			pos_y_s11 <= pos_y_s10;

			px_s12  <= sat32(42'(psx));
			py_s12  <= sat32(42'(psy));
			v2x_s12 <= v2x_s11;
			v2y_s12 <= v2y_s11;

			// wrap: lift negatives once
			px_s13  <= px_s12[31] ? 32'(33'($signed(px_s12)) + wx) : px_s13_keep(px_s12);
			py_s13  <= py_s12[31] ? 32'(33'($signed(py_s12)) + wy) : px_s13_keep(py_s12);
			v2x_s13 <= v2x_s12;
			v2y_s13 <= v2y_s12;

			// wrap: drop one screen size when non-negative and past the edge
			npx_q <= (!px_s13[31] && ({1'b0, px_s13} >= wx)) ? 32'({1'b0, px_s13} - wx) : px_s13;
			npy_q <= (!py_s13[31] && ({1'b0, py_s13} >= wy)) ? 32'({1'b0, py_s13} - wy) : py_s13;
			nvx_q <= v2x_s13;
			nvy_q <= v2y_s13;
		end
	end

	function automatic logic [31:0] px_s13_keep(input logic [31:0] v);
		px_s13_keep = v;
	endfunction

	assign out_valid = out_vld_q;
	assign new_pos_x = npx_q;
	assign new_pos_y = npy_q;
	assign new_vel_x = nvx_q;
	assign new_vel_y = nvy_q;

endmodule
